// ===== src/kmeans_clustering_engine_assert.svh =====
// Assertion macros shared by the engine's RTL.
`ifndef KMEANS_CLUSTERING_ENGINE_ASSERT_SVH
`define KMEANS_CLUSTERING_ENGINE_ASSERT_SVH

// Same-cycle implication, disabled in reset.
`define KCE_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled in reset.
`define KCE_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== src/kce_pkg.sv =====
package kce_pkg;

	localparam int VAL_W   = 16;
	localparam int SIDX_W  = 10;
	localparam int CIDX_W  = 4;
	localparam int FIDX_W  = 3;
	localparam int SUM_W   = 27;
	localparam int CNT_W   = 11;
	localparam int DIST_W  = 40;
	localparam int ITER_W  = 16;
	localparam int DS_AW   = SIDX_W + FIDX_W;
	localparam int CEN_AW  = CIDX_W + FIDX_W;
	localparam int MAX_SAMPLES  = 1 << SIDX_W;
	localparam int MAX_CLUSTERS = 1 << CIDX_W;
	localparam int MAX_FEATURES = 1 << FIDX_W;

	localparam logic [1:0] OP_WRITE    = 2'd0;
	localparam logic [1:0] OP_RUN      = 2'd1;
	localparam logic [1:0] OP_READ_ASG = 2'd2;
	localparam logic [1:0] OP_READ_CEN = 2'd3;

	localparam logic [2:0] REG_SAMPLE_COUNT  = 3'd0;
	localparam logic [2:0] REG_FEATURE_COUNT = 3'd1;
	localparam logic [2:0] REG_CLUSTER_COUNT = 3'd2;
	localparam logic [2:0] REG_TOLERANCE     = 3'd3;
	localparam logic [2:0] REG_ITER_LIMIT    = 3'd4;

	typedef struct packed {
		logic [1:0]              op;
		logic [SIDX_W-1:0]       sample_index;
		logic [CIDX_W-1:0]       cluster_index;
		logic [FIDX_W-1:0]       feature_index;
		logic signed [VAL_W-1:0] feature_value;
	} in_t;

	typedef struct packed {
		logic signed [VAL_W-1:0] centroid_value;
		logic [CIDX_W-1:0]       assigned_cluster;
		logic [ITER_W-1:0]       iterations_done;
		logic                    converged;
	} out_t;

	typedef struct packed {
		logic busy;
		logic done;
	} div_stat_t;

endpackage

// ===== src/kmeans_clustering_engine.sv =====
// channel  | valid     | stall     | payload
// in       | in_valid  | in_stall  | in_data  (kce_pkg::in_t)
// out      | out_valid | out_stall | out_data (kce_pkg::out_t)
// cfg      | psel/penable/pwrite, 64-bit data, register i at 8*i
// Writes answer from ST_IDLE; reads pass ST_RDW for the registered RAM read.
// A run seeds centroid c from sample c; each iteration makes the assignment
// pass over all samples, the update (a bit-serial divide per feature of each
// non-empty cluster; empty ones keep their centroid), and bookkeeping.
// Reset clears control state only; stores are undefined until written.
// in_stall is high while the sequencer is busy or the result is not taken.
module kmeans_clustering_engine (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_stall,
	input  kce_pkg::in_t   in_data,
	output logic           out_valid,
	input  logic           out_stall,
	output kce_pkg::out_t  out_data,
	input  logic           psel,
	input  logic           penable,
	input  logic           pwrite,
	input  logic [5:0]     paddr,
	input  logic [63:0]    pwdata,
	output logic [63:0]    prdata,
	output logic           pready
);
	import kce_pkg::*;

	`include "kmeans_clustering_engine_assert.svh"

	localparam int NST = 20;
	typedef enum logic [NST-1:0] {
		ST_IDLE  = NST'(1) << 0,
		ST_RDW   = NST'(1) << 1,
		ST_SD_RD = NST'(1) << 2,
		ST_SD_WR = NST'(1) << 3,
		ST_IT_ST = NST'(1) << 4,
		ST_A_RD  = NST'(1) << 5,
		ST_A_SQ  = NST'(1) << 6,
		ST_A_W1  = NST'(1) << 7,
		ST_A_CMP = NST'(1) << 8,
		ST_A_WR  = NST'(1) << 9,
		ST_S_RD  = NST'(1) << 10,
		ST_S_WR  = NST'(1) << 11,
		ST_U_CHK = NST'(1) << 12,
		ST_U_RD  = NST'(1) << 13,
		ST_U_GO  = NST'(1) << 14,
		ST_U_DIV = NST'(1) << 15,
		ST_U_SQ  = NST'(1) << 16,
		ST_U_W1  = NST'(1) << 17,
		ST_U_MAX = NST'(1) << 18,
		ST_FIN   = NST'(1) << 19
	} state_t;

	state_t state_q;

	// configuration
	logic [10:0] sample_count_q;
	logic [3:0]  feature_count_q;
	logic [4:0]  cluster_count_q;
	logic [39:0] tolerance_q;
	logic [15:0] iter_limit_q;
	logic        cfg_wr;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sample_count_q  <= 11'd1;
			feature_count_q <= 4'd1;
			cluster_count_q <= 5'd1;
			tolerance_q     <= '0;
			iter_limit_q    <= '0;
		end else if (cfg_wr) begin
			unique case (paddr[5:3])
				REG_SAMPLE_COUNT:  sample_count_q  <= pwdata[10:0];
				REG_FEATURE_COUNT: feature_count_q <= pwdata[3:0];
				REG_CLUSTER_COUNT: cluster_count_q <= pwdata[4:0];
				REG_TOLERANCE:     tolerance_q     <= pwdata[39:0];
				REG_ITER_LIMIT:    iter_limit_q    <= pwdata[15:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[5:3])
			REG_SAMPLE_COUNT:  prdata = 64'(sample_count_q);
			REG_FEATURE_COUNT: prdata = 64'(feature_count_q);
			REG_CLUSTER_COUNT: prdata = 64'(cluster_count_q);
			REG_TOLERANCE:     prdata = 64'(tolerance_q);
			REG_ITER_LIMIT:    prdata = 64'(iter_limit_q);
			default:           prdata = '0;
		endcase
	end

	// clamped active counts, as last index
	logic [SIDX_W-1:0] ns_m1;
	logic [FIDX_W-1:0] nf_m1;
	logic [CIDX_W-1:0] nc_m1;
	logic [10:0]       ns_eff;
	logic [10:0]       nc_eff;
	logic [ITER_W-1:0] lim;

	always_comb begin
		if (sample_count_q == 11'd0) begin
			ns_eff = 11'd1;
		end else if (sample_count_q > 11'(MAX_SAMPLES)) begin
			ns_eff = 11'(MAX_SAMPLES);
		end else begin
			ns_eff = sample_count_q;
		end
		ns_m1 = SIDX_W'(ns_eff - 11'd1);
		if (feature_count_q == 4'd0) begin
			nf_m1 = '0;
		end else if (feature_count_q > 4'(MAX_FEATURES)) begin
			nf_m1 = FIDX_W'(MAX_FEATURES - 1);
		end else begin
			nf_m1 = FIDX_W'(feature_count_q - 4'd1);
		end
		if (cluster_count_q == 5'd0) begin
			nc_eff = 11'd1;
		end else if (cluster_count_q > 5'(MAX_CLUSTERS)) begin
			nc_eff = 11'(MAX_CLUSTERS);
		end else begin
			nc_eff = 11'(cluster_count_q);
		end
		if (nc_eff > ns_eff) begin
			nc_eff = ns_eff;
		end
		nc_m1 = CIDX_W'(nc_eff - 11'd1);
		lim = (iter_limit_q == '0) ? {ITER_W{1'b1}} : iter_limit_q;
	end

	// sequencer registers
	logic [SIDX_W-1:0]       s_q;
	logic [CIDX_W-1:0]       c_q;
	logic [FIDX_W-1:0]       f_q;
	logic [CIDX_W-1:0]       best_q;
	logic [DIST_W-1:0]       bestd_q;
	logic [DIST_W-1:0]       worst_q;
	logic [ITER_W-1:0]       iter_q;
	logic [ITER_W-1:0]       last_iter_q;
	logic                    last_conv_q;
	logic signed [VAL_W-1:0] oldc_q;
	logic [1:0]              rd_op_q;
	logic [CNT_W-1:0]        counts_q [MAX_CLUSTERS];
	logic [MAX_CLUSTERS*MAX_FEATURES-1:0] sum_vld_q;
	logic                    out_valid_q;
	out_t                    out_q;

	// memories
	logic                    ds_we;
	logic [DS_AW-1:0]        ds_raddr;
	logic [VAL_W-1:0]        ds_rdata;
	logic                    cen_we;
	logic [CEN_AW-1:0]       cen_waddr;
	logic [VAL_W-1:0]        cen_wdata;
	logic [CEN_AW-1:0]       cen_raddr;
	logic [VAL_W-1:0]        cen_rdata;
	logic                    sum_we;
	logic [SUM_W-1:0]        sum_wdata;
	logic [SUM_W-1:0]        sum_rdata;
	logic                    asg_we;
	logic [CIDX_W-1:0]       asg_rdata;
	logic [CEN_AW-1:0]       bf_addr;
	logic                    in_acc;

	assign in_stall = !(state_q == ST_IDLE && (!out_valid_q || !out_stall));
	assign in_acc   = in_valid && !in_stall;
	assign bf_addr  = {best_q, f_q};

	assign ds_we    = in_acc && in_data.op == OP_WRITE;
	assign ds_raddr = (state_q == ST_SD_RD) ? {SIDX_W'(c_q), f_q} : {s_q, f_q};

	kce_ram #(.WIDTH(VAL_W), .DEPTH(MAX_SAMPLES*MAX_FEATURES)) u_ds_ram (
		.clk(clk), .we(ds_we),
		.waddr({in_data.sample_index, in_data.feature_index}),
		.wdata(in_data.feature_value),
		.raddr(ds_raddr), .rdata(ds_rdata)
	);

	always_comb begin
		priority case (1'b1)
			state_q == ST_A_RD: cen_raddr = {c_q, f_q};
			state_q == ST_U_RD: cen_raddr = bf_addr;
			default:            cen_raddr = {in_data.cluster_index, in_data.feature_index};
		endcase
	end

	// shared square-accumulate and divider
	logic [DIST_W-1:0]        acc;
	logic                     sq_en;
	logic                     sq_clr;
	logic signed [VAL_W-1:0]  sq_a;
	logic signed [VAL_W-1:0]  sq_b;
	div_stat_t                div_stat;
	logic signed [SUM_W-1:0]  quot;
	logic signed [VAL_W-1:0]  fresh;

	assign fresh     = quot[VAL_W-1:0];
	assign cen_we    = state_q == ST_SD_WR || state_q == ST_U_SQ;
	assign cen_waddr = (state_q == ST_SD_WR) ? {c_q, f_q} : bf_addr;
	assign cen_wdata = (state_q == ST_SD_WR) ? ds_rdata : fresh;

	kce_ram #(.WIDTH(VAL_W), .DEPTH(MAX_CLUSTERS*MAX_FEATURES)) u_cen_ram (
		.clk(clk), .we(cen_we), .waddr(cen_waddr), .wdata(cen_wdata),
		.raddr(cen_raddr), .rdata(cen_rdata)
	);

	assign sum_we    = state_q == ST_S_WR;
	assign sum_wdata = (sum_vld_q[bf_addr] ? sum_rdata : '0)
		+ SUM_W'($signed(ds_rdata));

	kce_ram #(.WIDTH(SUM_W), .DEPTH(MAX_CLUSTERS*MAX_FEATURES)) u_sum_ram (
		.clk(clk), .we(sum_we), .waddr(bf_addr), .wdata(sum_wdata),
		.raddr(bf_addr), .rdata(sum_rdata)
	);

	assign asg_we = state_q == ST_A_WR;

	kce_ram #(.WIDTH(CIDX_W), .DEPTH(MAX_SAMPLES)) u_asg_ram (
		.clk(clk), .we(asg_we), .waddr(s_q), .wdata(best_q),
		.raddr(in_data.sample_index), .rdata(asg_rdata)
	);

	assign sq_en  = state_q == ST_A_SQ || state_q == ST_U_SQ;
	assign sq_clr = state_q == ST_IT_ST || state_q == ST_A_CMP || state_q == ST_U_CHK;
	assign sq_a   = (state_q == ST_U_SQ) ? fresh : $signed(ds_rdata);
	assign sq_b   = (state_q == ST_U_SQ) ? oldc_q : $signed(cen_rdata);

	kce_sqacc u_sqacc (
		.clk(clk), .clr(sq_clr), .en(sq_en), .a(sq_a), .b(sq_b), .acc(acc)
	);

	kce_div u_div (
		.clk(clk), .arst_n(arst_n), .start(state_q == ST_U_GO),
		.dividend(sum_vld_q[bf_addr] ? $signed(sum_rdata) : '0),
		.divisor(counts_q[best_q]), .stat(div_stat), .quot(quot)
	);

	logic f_last;
	logic c_last;
	logic b_last;
	assign f_last = f_q == nf_m1;
	assign c_last = c_q == nc_m1;
	assign b_last = best_q == nc_m1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
			out_q       <= '0;
			rd_op_q     <= OP_WRITE;
			last_iter_q <= '0;
			last_conv_q <= 1'b0;
			sum_vld_q   <= '0;
			s_q         <= '0;
			c_q         <= '0;
			f_q         <= '0;
			best_q      <= '0;
			bestd_q     <= '0;
			worst_q     <= '0;
			oldc_q      <= '0;
			iter_q      <= '0;
			for (int i = 0; i < MAX_CLUSTERS; i++) begin
				counts_q[i] <= '0;
			end
		end else begin
			if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (in_acc) begin
						rd_op_q <= in_data.op;
						unique case (in_data.op)
							OP_WRITE: begin
								out_valid_q <= 1'b1;
								out_q <= '{centroid_value: '0, assigned_cluster: '0,
									iterations_done: last_iter_q, converged: last_conv_q};
							end
							OP_RUN: begin
								last_conv_q <= 1'b0;
								c_q <= '0;
								f_q <= '0;
								state_q <= ST_SD_RD;
							end
							default: state_q <= ST_RDW;
						endcase
					end
				end
				ST_RDW: begin
					out_valid_q <= 1'b1;
					out_q <= '{centroid_value: (rd_op_q == OP_READ_CEN) ? $signed(cen_rdata) : '0,
						assigned_cluster: (rd_op_q == OP_READ_ASG) ? asg_rdata : '0,
						iterations_done: last_iter_q, converged: last_conv_q};
					state_q <= ST_IDLE;
				end
				ST_SD_RD: state_q <= ST_SD_WR;
				ST_SD_WR: begin
					f_q <= f_last ? '0 : f_q + FIDX_W'(1);
					if (f_last) begin
						c_q <= c_q + CIDX_W'(1);
					end
					if (f_last && c_last) begin
						iter_q  <= ITER_W'(1);
						state_q <= ST_IT_ST;
					end else begin
						state_q <= ST_SD_RD;
					end
				end
				ST_IT_ST: begin
					sum_vld_q <= '0;
					for (int i = 0; i < MAX_CLUSTERS; i++) begin
						counts_q[i] <= '0;
					end
					worst_q <= '0;
					s_q <= '0;
					c_q <= '0;
					f_q <= '0;
					state_q <= ST_A_RD;
				end
				ST_A_RD: state_q <= ST_A_SQ;
				ST_A_SQ: begin
					if (f_last) begin
						state_q <= ST_A_W1;
					end else begin
						f_q <= f_q + FIDX_W'(1);
						state_q <= ST_A_RD;
					end
				end
				ST_A_W1: state_q <= ST_A_CMP;
				ST_A_CMP: begin
					// lowest index wins ties
					if (c_q == '0 || acc < bestd_q) begin
						best_q  <= c_q;
						bestd_q <= acc;
					end
					f_q <= '0;
					if (c_last) begin
						state_q <= ST_A_WR;
					end else begin
						c_q <= c_q + CIDX_W'(1);
						state_q <= ST_A_RD;
					end
				end
				ST_A_WR: begin
					counts_q[best_q] <= counts_q[best_q] + CNT_W'(1);
					state_q <= ST_S_RD;
				end
				ST_S_RD: state_q <= ST_S_WR;
				ST_S_WR: begin
					sum_vld_q[bf_addr] <= 1'b1;
					if (!f_last) begin
						f_q <= f_q + FIDX_W'(1);
						state_q <= ST_S_RD;
					end else begin
						f_q <= '0;
						c_q <= '0;
						if (s_q == ns_m1) begin
							best_q  <= '0;
							state_q <= ST_U_CHK;
						end else begin
							s_q <= s_q + SIDX_W'(1);
							state_q <= ST_A_RD;
						end
					end
				end
				ST_U_CHK: begin
					f_q <= '0;
					if (counts_q[best_q] != '0) begin
						state_q <= ST_U_RD;
					end else if (b_last) begin
						state_q <= ST_FIN;
					end else begin
						best_q <= best_q + CIDX_W'(1);
					end
				end
				ST_U_RD: state_q <= ST_U_GO;
				ST_U_GO: begin
					oldc_q  <= $signed(cen_rdata);
					state_q <= ST_U_DIV;
				end
				ST_U_DIV: begin
					if (div_stat.done) begin
						state_q <= ST_U_SQ;
					end
				end
				ST_U_SQ: begin
					if (f_last) begin
						state_q <= ST_U_W1;
					end else begin
						f_q <= f_q + FIDX_W'(1);
						state_q <= ST_U_RD;
					end
				end
				ST_U_W1: state_q <= ST_U_MAX;
				ST_U_MAX: begin
					if (acc > worst_q) begin
						worst_q <= acc;
					end
					if (b_last) begin
						state_q <= ST_FIN;
					end else begin
						best_q  <= best_q + CIDX_W'(1);
						state_q <= ST_U_CHK;
					end
				end
				ST_FIN: begin
					// stop on tolerance, on limit, or at a fixed point
					if (worst_q < tolerance_q) begin
						last_conv_q <= 1'b1;
						last_iter_q <= iter_q;
						state_q     <= ST_IDLE;
					end else if (iter_q >= lim) begin
						last_iter_q <= iter_q;
						state_q     <= ST_IDLE;
					end else if (worst_q == '0) begin
						last_iter_q <= lim;
						state_q     <= ST_IDLE;
					end else begin
						iter_q  <= iter_q + ITER_W'(1);
						state_q <= ST_IT_ST;
					end
					if (worst_q < tolerance_q || iter_q >= lim || worst_q == '0) begin
						out_valid_q <= 1'b1;
						out_q <= '{centroid_value: '0, assigned_cluster: '0,
							iterations_done: (worst_q < tolerance_q || iter_q >= lim)
								? iter_q : lim,
							converged: worst_q < tolerance_q};
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	`KCE_ASSERT_NOW(a_busy_stalls, state_q != ST_IDLE, in_stall, "input taken while busy")
	`KCE_ASSERT_NOW(a_div_only_in_update, div_stat.busy,
		state_q == ST_U_DIV || state_q == ST_U_GO, "divider running outside update")
	`KCE_ASSERT_NEXT(a_run_seeds, in_acc && in_data.op == OP_RUN,
		state_q == ST_SD_RD, "run did not start seeding")
	`KCE_ASSERT_NEXT(a_conv_flag, state_q == ST_FIN && worst_q < tolerance_q,
		last_conv_q && out_valid_q, "converged run not reported")
endmodule

// ===== src/kce_ram.sv =====
module kce_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end
endmodule

// ===== src/kce_div.sv =====
module kce_div (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               start,
	input  logic signed [kce_pkg::SUM_W-1:0]   dividend,
	input  logic [kce_pkg::CNT_W-1:0]          divisor,
	output kce_pkg::div_stat_t                 stat,
	output logic signed [kce_pkg::SUM_W-1:0]   quot
);
	import kce_pkg::*;

	localparam int CW = $clog2(SUM_W + 1);

	logic [SUM_W-1:0] q_q;
	logic [CNT_W:0]   rem_q;
	logic [CNT_W-1:0] div_q;
	logic             neg_q;
	logic [CW-1:0]    cnt_q;
	logic             busy_q;
	logic             done_q;
	logic [CNT_W:0]   rem_sh;
	logic             fits;

	// one quotient bit per cycle, restoring
	assign rem_sh = {rem_q[CNT_W-1:0], q_q[SUM_W-1]};
	assign fits   = rem_sh >= {1'b0, div_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CW'(SUM_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - CW'(1);
				if (cnt_q == CW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			q_q   <= dividend[SUM_W-1] ? SUM_W'(-dividend) : dividend;
			neg_q <= dividend[SUM_W-1];
			rem_q <= '0;
			div_q <= divisor;
		end else if (busy_q) begin
			rem_q <= fits ? (rem_sh - {1'b0, div_q}) : rem_sh;
			q_q   <= {q_q[SUM_W-2:0], fits};
		end
	end

	assign quot = neg_q ? -$signed(q_q) : $signed(q_q);
	assign stat = '{busy: busy_q, done: done_q};
endmodule

// ===== src/kce_sqacc.sv =====
module kce_sqacc (
	input  logic                             clk,
	input  logic                             clr,
	input  logic                             en,
	input  logic signed [kce_pkg::VAL_W-1:0] a,
	input  logic signed [kce_pkg::VAL_W-1:0] b,
	output logic [kce_pkg::DIST_W-1:0]       acc
);
	import kce_pkg::*;

	logic signed [VAL_W:0]   diff;
	logic [2*VAL_W+1:0]      sq_s1;
	logic                    en_s1;
	logic [DIST_W-1:0]       acc_q;

	assign diff = {a[VAL_W-1], a} - {b[VAL_W-1], b};

	always_ff @(posedge clk) begin
		sq_s1 <= (2*VAL_W+2)'(diff * diff);
		en_s1 <= en;
		if (clr) begin
			acc_q <= '0;
		end else if (en_s1) begin
			acc_q <= acc_q + DIST_W'(sq_s1);
		end
	end

	assign acc = acc_q;
endmodule
